@@ hdl/pqd_pkg.sv @@
package pqd_pkg;

	// Sample formats selected by the configuration register.
	typedef enum logic [1:0] {
		FMT_S32        = 2'd0,
		FMT_S24_LJ     = 2'd1,
		FMT_S24_PACKED = 2'd2,
		FMT_S16_DITHER = 2'd3
	} fmt_t;

	// Working width of the scaled products.
	localparam int ACC_W = 64;

	// Default position of the binary point of the input sample.
	localparam int INPUT_FRACTION_BITS_DEF = 28;

	// Full-scale factors are all 2^k - 1, so scaling is a shift and a subtract.
	localparam int S32_SCALE_SHIFT = 31;
	localparam int S24_SCALE_SHIFT = 23;
	localparam int S16_SCALE_SHIFT = 15;

	// Width of one dither fraction.
	localparam int DITHER_FRAC_W = 16;

	// Saturation limits.
	localparam logic signed [ACC_W-1:0] S24_MAX = 64'sd8388607;
	localparam logic signed [ACC_W-1:0] S24_MIN = -64'sd8388608;
	localparam logic signed [ACC_W-1:0] S16_MAX = 64'sd32767;
	localparam logic signed [ACC_W-1:0] S16_MIN = -64'sd32768;

	// Valid bytes in the output word for each format.
	localparam logic [2:0] BYTES_WORD   = 3'd4;
	localparam logic [2:0] BYTES_PACKED = 3'd3;
	localparam logic [2:0] BYTES_HALF   = 3'd2;

	// Reset value of the dither generator.
	localparam logic [31:0] DITHER_SEED = 32'h4D2A7F1B;

	// The two dither fractions used by one S16 sample.
	typedef struct packed {
		logic [DITHER_FRAC_W-1:0] frac_a;
		logic [DITHER_FRAC_W-1:0] frac_b;
	} dither_pair_t;

	// One step of the xorshift32 generator (shifts 13, 17, 5).
	function automatic logic [31:0] xorshift_step(input logic [31:0] r);
		logic [31:0] t;
		t = r ^ (r << 13);
		t = t ^ (t >> 17);
		t = t ^ (t << 5);
		return t;
	endfunction

endpackage

@@ hdl/pqd_dither.sv @@
module pqd_dither (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	output pqd_pkg::dither_pair_t pair
);

	logic [31:0] gen_q;
	logic [31:0] step1;
	logic [31:0] step2;

	// Two generator steps per S16 sample; the low halves are the fractions.
	always_comb begin
		step1       = pqd_pkg::xorshift_step(gen_q);
		step2       = pqd_pkg::xorshift_step(step1);
		pair.frac_a = step1[pqd_pkg::DITHER_FRAC_W-1:0];
		pair.frac_b = step2[pqd_pkg::DITHER_FRAC_W-1:0];
	end

	// Generator state moves only when an S16 beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= pqd_pkg::DITHER_SEED;
		end else if (advance) begin
			gen_q <= step2;
		end
	end

`ifndef SYNTHESIS
	// A nonzero seed never reaches the all-zero lockup state.
	a_gen_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		gen_q != 32'd0)
		else $error("dither generator reached zero");

	// Without an S16 beat the generator holds.
	a_gen_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> gen_q == $past(gen_q))
		else $error("dither generator moved without an S16 beat");

	// An S16 beat always moves the generator on.
	a_gen_moves: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> gen_q != $past(gen_q))
		else $error("dither generator did not advance");
`endif

endmodule

@@ hdl/pqd_quant.sv @@
module pqd_quant #(
	parameter int INPUT_FRACTION_BITS = pqd_pkg::INPUT_FRACTION_BITS_DEF
) (
	input  pqd_pkg::fmt_t        fmt,
	input  logic signed [31:0]   sample,
	input  pqd_pkg::dither_pair_t dither,
	output logic [31:0]          pcm_word,
	output logic [2:0]           byte_count
);

	localparam int ACC_W = pqd_pkg::ACC_W;
	localparam int SH_LO = INPUT_FRACTION_BITS;
	localparam int SH_HI = INPUT_FRACTION_BITS + pqd_pkg::DITHER_FRAC_W;
	localparam logic signed [ACC_W-1:0] ONE     = 64'sd1 <<< SH_LO;
	localparam logic signed [ACC_W-1:0] BIAS_LO = (64'sd1 <<< SH_LO) - 64'sd1;
	localparam logic signed [ACC_W-1:0] BIAS_HI = (64'sd1 <<< SH_HI) - 64'sd1;

	logic signed [ACC_W-1:0] s_w;
	logic signed [ACC_W-1:0] c_w;
	logic signed [ACC_W-1:0] d_w;
	logic signed [ACC_W-1:0] prod;
	logic signed [ACC_W-1:0] q;
	logic signed [ACC_W-1:0] q_sat24;
	logic signed [ACC_W-1:0] q_sat16;

	// Clamp to plus or minus one for S32 and left-justified S24, and build the scaled product for the format.
	always_comb begin
		s_w = ACC_W'(sample);
		if (s_w > ONE) begin
			c_w = ONE;
		end else if (s_w < -ONE) begin
			c_w = -ONE;
		end else begin
			c_w = s_w;
		end
		d_w = ACC_W'($signed({1'b0, dither.frac_a})) - ACC_W'($signed({1'b0, dither.frac_b}));
		unique case (fmt)
			pqd_pkg::FMT_S32: begin
				prod = (c_w <<< pqd_pkg::S32_SCALE_SHIFT) - c_w;
			end
			pqd_pkg::FMT_S24_LJ: begin
				prod = (c_w <<< pqd_pkg::S24_SCALE_SHIFT) - c_w;
			end
			pqd_pkg::FMT_S24_PACKED: begin
				prod = (s_w <<< pqd_pkg::S24_SCALE_SHIFT) - s_w;
			end
			default: begin
				prod = (((s_w <<< pqd_pkg::S16_SCALE_SHIFT) - s_w) <<< pqd_pkg::DITHER_FRAC_W)
					+ (d_w <<< SH_LO);
			end
		endcase
	end

	// Truncating shift toward zero: negative values get a bias first.
	always_comb begin
		if (fmt == pqd_pkg::FMT_S16_DITHER) begin
			q = $signed(prod + (prod[ACC_W-1] ? BIAS_HI : '0)) >>> SH_HI;
		end else begin
			q = $signed(prod + (prod[ACC_W-1] ? BIAS_LO : '0)) >>> SH_LO;
		end
	end

	// Saturation commutes with truncation because the limits are whole numbers.
	always_comb begin
		if (q > pqd_pkg::S24_MAX) begin
			q_sat24 = pqd_pkg::S24_MAX;
		end else if (q < pqd_pkg::S24_MIN) begin
			q_sat24 = pqd_pkg::S24_MIN;
		end else begin
			q_sat24 = q;
		end
		if (q > pqd_pkg::S16_MAX) begin
			q_sat16 = pqd_pkg::S16_MAX;
		end else if (q < pqd_pkg::S16_MIN) begin
			q_sat16 = pqd_pkg::S16_MIN;
		end else begin
			q_sat16 = q;
		end
	end

	// Pack the word little-endian; narrow formats leave unused high bytes zero, left-justified S24 a zero low byte.
	always_comb begin
		unique case (fmt)
			pqd_pkg::FMT_S32: begin
				pcm_word   = q[31:0];
				byte_count = pqd_pkg::BYTES_WORD;
			end
			pqd_pkg::FMT_S24_LJ: begin
				pcm_word   = {q[23:0], 8'h00};
				byte_count = pqd_pkg::BYTES_WORD;
			end
			pqd_pkg::FMT_S24_PACKED: begin
				pcm_word   = {8'h00, q_sat24[23:0]};
				byte_count = pqd_pkg::BYTES_PACKED;
			end
			default: begin
				pcm_word   = {16'h0000, q_sat16[15:0]};
				byte_count = pqd_pkg::BYTES_HALF;
			end
		endcase
	end

endmodule

@@ hdl/pcm_sample_quantizer_tpdf_dither_top.sv @@
// Channel   Direction  tdata fields (low bit up)             tlast
// s_axis    in         sample_value[31:0]                    block_end
// m_axis    out        pcm_word[31:0], byte_count[34:32]     block_end_out
// cfg       in         cfg_wdata = sample_format[1:0]        (write on cfg_we)
//
// Two register stages: an input register and a result register. A taken beat
// passes through the input register into the result register and leaves from
// there; one beat is taken every cycle while the result register is not stalled.
// The result register is the only point of backpressure; stage one keeps
// taking beats while its slot is empty or moving on.
// Reset clears the valid bits, the format register (S32) and the dither
// generator; payload registers are not reset.
module pcm_sample_quantizer_tpdf_dither_top #(
	parameter int INPUT_FRACTION_BITS = pqd_pkg::INPUT_FRACTION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // sample_value[31:0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // pcm_word[31:0], byte_count[34:32], zero fill
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata
);

	pqd_pkg::fmt_t        fmt_q;
	pqd_pkg::fmt_t        fmt_s1;
	logic                 valid_s1;
	logic signed [31:0]   sample_s1;
	logic                 last_s1;
	pqd_pkg::dither_pair_t dither_s1;
	pqd_pkg::dither_pair_t dither_now;
	logic                 valid_s2;
	logic [31:0]          word_s2;
	logic [2:0]           bytes_s2;
	logic                 last_s2;
	logic                 adv_s2;
	logic                 take_in;
	logic [31:0]          word_c;
	logic [2:0]           bytes_c;

	// Handshake: the result register moves when empty or drained.
	assign adv_s2   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s2;
	assign take_in  = s_tvalid && s_tready;

	// Format register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= pqd_pkg::FMT_S32;
		end else if (cfg_we) begin
			fmt_q <= pqd_pkg::fmt_t'(cfg_wdata);
		end
	end

	// Dither generator steps only for S16 beats.
	pqd_dither u_dither (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (take_in && (fmt_q == pqd_pkg::FMT_S16_DITHER)),
		.pair    (dither_now)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			sample_s1 <= s_tdata;
			last_s1   <= s_tlast;
			fmt_s1    <= fmt_q;
			dither_s1 <= dither_now;
		end
	end

	pqd_quant #(
		.INPUT_FRACTION_BITS (INPUT_FRACTION_BITS)
	) u_quant (
		.fmt        (fmt_s1),
		.sample     (sample_s1),
		.dither     (dither_s1),
		.pcm_word   (word_c),
		.byte_count (bytes_c)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			word_s2  <= word_c;
			bytes_s2 <= bytes_c;
			last_s2  <= last_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'b00000, bytes_s2, word_s2};
	assign m_tlast  = last_s2;

`ifndef SYNTHESIS
	// Byte count is always one of the three legal sizes.
	a_bytes_legal: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (bytes_s2 == pqd_pkg::BYTES_WORD || bytes_s2 == pqd_pkg::BYTES_PACKED
			|| bytes_s2 == pqd_pkg::BYTES_HALF))
		else $error("illegal byte count");

	// Narrow formats leave the unused high bytes zero.
	a_zero_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && bytes_s2 == pqd_pkg::BYTES_HALF) |-> word_s2[31:16] == 16'h0000)
		else $error("S16 word has nonzero high bytes");

	a_zero_fill24: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && bytes_s2 == pqd_pkg::BYTES_PACKED) |-> word_s2[31:24] == 8'h00)
		else $error("packed S24 word has nonzero high byte");

	// A beat held in stage one is not dropped while the result stalls.
	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s2) |=> valid_s1 && $stable(sample_s1))
		else $error("stage one beat lost under stall");
`endif

endmodule
